[sv/gift128_block_cipher_defines.svh]
// Assertion macros for the cipher RTL.
`ifndef GIFT128_BLOCK_CIPHER_DEFINES_SVH
`define GIFT128_BLOCK_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define GIFT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GIFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GIFT_ASSERT(lbl, clk, rst_n, prop, msg)
`define GIFT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/gift_pkg.sv]
// Types, tables and round functions of the GIFT-128 cipher.
`default_nettype none

package gift_pkg;

    localparam int ROUNDS    = 40;
    localparam int RND_W     = $clog2(ROUNDS);
    localparam int HALF_W    = 64;
    localparam int BLK_W     = 2 * HALF_W;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);

    // operation codes carried by the kind bit
    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef logic [BLK_W-1:0] blk_t;

    // one pipeline stage: valid bit, operation, block and key for this round
    typedef struct packed {
        logic valid;
        logic kind;
        blk_t blk;
        blk_t key;
    } stage_t;

    localparam logic [3:0] SBOX [16] = '{
        4'h1, 4'hA, 4'h4, 4'hC, 4'h6, 4'hF, 4'h3, 4'h9,
        4'h2, 4'hD, 4'hB, 4'h7, 4'h5, 4'h0, 4'h8, 4'hE
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'hD, 4'h0, 4'h8, 4'h6, 4'h2, 4'hC, 4'h4, 4'hB,
        4'hE, 4'h7, 4'h1, 4'hA, 4'h3, 4'h9, 4'hF, 4'h5
    };
    localparam logic [5:0] RCON [40] = '{
        6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
        6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
        6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
        6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38,
        6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A
    };

    // nibble substitution over all 32 nibbles
    function automatic blk_t sub_cells(blk_t x, logic inv);
        blk_t y;
        for (int i = 0; i < BLK_W / 4; i++) begin
            y[4*i +: 4] = inv ? SBOX_INV[x[4*i +: 4]] : SBOX[x[4*i +: 4]];
        end
        return y;
    endfunction

    // destination of bit i under the forward bit permutation
    function automatic logic [6:0] perm_dest(int i);
        int q;
        int m;
        int b;
        q = i / 16;
        m = i % 16;
        b = i % 4;
        return 7'(4 * q + 32 * ((3 * (m / 4) + b) % 4) + b);
    endfunction

    function automatic blk_t perm_fwd(blk_t x);
        blk_t y;
        for (int i = 0; i < BLK_W; i++) begin
            y[perm_dest(i)] = x[i];
        end
        return y;
    endfunction

    function automatic blk_t perm_inv(blk_t x);
        blk_t y;
        for (int i = 0; i < BLK_W; i++) begin
            y[i] = x[perm_dest(i)];
        end
        return y;
    endfunction

    // round key on bits 4i+1 / 4i+2, constant on bits 4j+3, flip of bit 127
    function automatic blk_t key_mix(blk_t s, blk_t k, logic [5:0] rc);
        blk_t y;
        y = s;
        for (int i = 0; i < 32; i++) begin
            y[4*i+1] = y[4*i+1] ^ k[i];
            y[4*i+2] = y[4*i+2] ^ k[64+i];
        end
        for (int i = 0; i < 6; i++) begin
            y[4*i+3] = y[4*i+3] ^ rc[i];
        end
        y[BLK_W-1] = ~y[BLK_W-1];
        return y;
    endfunction

    // forward key update: words shift down by two, the two low words rotate in on top
    function automatic blk_t key_next(blk_t k);
        return {k[17:16], k[31:18], k[11:0], k[15:12], k[127:96], k[95:64], k[63:32]};
    endfunction

    // inverse of key_next
    function automatic blk_t key_prev(blk_t n);
        return {n[95:64], n[63:32], n[31:0], n[125:112], n[127:126],
                n[99:96], n[111:100]};
    endfunction

    // key of the last round; a fixed rewiring of the master key
    function automatic blk_t key_final(blk_t k);
        blk_t y;
        y = k;
        for (int r = 1; r < ROUNDS; r++) begin
            y = key_next(y);
        end
        return y;
    endfunction

endpackage

`default_nettype wire

[sv/gift_if.sv]
// Channel interfaces: block requests, block results, configuration writes.
`default_nettype none

interface gift_in_if;
    import gift_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [HALF_W-1:0] data_high;
    logic [HALF_W-1:0] data_low;
    modport source (output valid, kind, data_high, data_low, input ready);
    modport sink   (input valid, kind, data_high, data_low, output ready);
endinterface

interface gift_out_if;
    import gift_pkg::*;
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface gift_cfg_if;
    import gift_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [HALF_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/gift_stage.sv]
// One registered cipher round, encrypt or decrypt per beat.
`default_nettype none

module gift_stage (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         en,
    input  wire  [gift_pkg::RND_W-1:0]  rnd,
    input  gift_pkg::stage_t            prev,
    output gift_pkg::stage_t            curr
);
    import gift_pkg::*;

    logic             valid_reg;
    logic             kind_reg;
    blk_t             blk_reg;
    blk_t             key_reg;
    blk_t             blk_next;
    blk_t             key_next_v;
    blk_t             enc_blk;
    blk_t             dec_blk;
    logic [RND_W-1:0] dec_rnd;

    // decryption walks the rounds from the top
    assign dec_rnd = RND_W'(ROUNDS - 1) - rnd;

    // both round directions, picked by the beat's kind
    always_comb
    begin
        enc_blk = key_mix(perm_fwd(sub_cells(prev.blk, 1'b0)), prev.key, RCON[rnd]);
        dec_blk = sub_cells(perm_inv(key_mix(prev.blk, prev.key, RCON[dec_rnd])),
                            1'b1);
        if (prev.kind == KIND_DEC)
        begin
            blk_next   = dec_blk;
            key_next_v = key_prev(prev.key);
        end
        else
        begin
            blk_next   = enc_blk;
            key_next_v = key_next(prev.key);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= prev.kind;
            blk_reg  <= blk_next;
            key_reg  <= key_next_v;
        end
    end

    assign curr = '{valid: valid_reg, kind: kind_reg, blk: blk_reg, key: key_reg};

endmodule

`default_nettype wire

[sv/gift_skid.sv]
// Output skid register between the round pipeline and the result channel.
`default_nettype none

`include "gift128_block_cipher_defines.svh"

module gift_skid (
    input  wire               clk,
    input  wire               rst_n,
    input  gift_pkg::stage_t  last,
    output logic              en,
    gift_out_if.source        rsp
);
    import gift_pkg::*;

    logic skid_valid_reg;
    logic skid_valid_next;
    blk_t skid_blk_reg;
    blk_t shown;

    // pipeline moves while the skid slot is free
    assign en = !skid_valid_reg;

    assign shown           = skid_valid_reg ? skid_blk_reg : last.blk;
    assign rsp.valid       = skid_valid_reg | last.valid;
    assign rsp.result_high = shown[BLK_W-1:HALF_W];
    assign rsp.result_low  = shown[HALF_W-1:0];

    // slot fills on a stalled beat, drains when taken
    assign skid_valid_next = (skid_valid_reg | last.valid) & !rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_blk_reg <= last.blk;
        end
    end

    `GIFT_ASSERT(a_skid_fill, clk, rst_n, $rose(skid_valid_reg) |-> $past(last.valid && !rsp.ready), "skid filled without a stalled beat")
    `GIFT_ASSERT(a_skid_hold, clk, rst_n, skid_valid_reg && !rsp.ready |=> skid_valid_reg && $stable(skid_blk_reg), "skid beat lost while stalled")
    `GIFT_ASSERT(a_skid_drain, clk, rst_n, skid_valid_reg && rsp.ready |=> !skid_valid_reg, "skid beat repeated after handoff")

endmodule

`default_nettype wire

[sv/gift128_block_cipher.sv]
// GIFT-128/128 block cipher, one round per pipeline stage.
//
// Channels: cfg writes the key (index 0 key_high, index 1 key_low) and is
// always ready; the user writes it only while no block is in flight; the
// block does not enforce this. req carries one block per beat with kind
// 0 to encrypt, 1 to decrypt. rsp returns the processed block, one beat
// per request beat, in order. Throughput: one block per cycle while rsp
// takes each beat, any mix of encrypt and decrypt. Path: each beat
// passes the 40 registered round stages, each holding one full round
// and its key update; rsp shows the last stage or the held skid beat.
// Decrypt beats start from the last round key, a fixed rewiring of the key.
// Reset: all stage valid bits, the skid slot and both key registers clear.
// Stall: a beat that rsp does not take moves into a one-beat skid slot;
// the pipeline then freezes and req.ready drops until the slot drains.
// No beat is lost or repeated.
`default_nettype none

module gift128_block_cipher (
    input  wire         clk,
    input  wire         rst_n,
    gift_cfg_if.sink    cfg,
    gift_in_if.sink     req,
    gift_out_if.source  rsp
);
    import gift_pkg::*;

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    blk_t              key_full;
    logic              en;
    stage_t            pipe [ROUNDS+1];

    // key registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_KEY_HIGH: key_high_reg <= cfg.data;
                CFG_KEY_LOW:  key_low_reg  <= cfg.data;
                default:      ;
            endcase
        end
    end

    assign key_full = {key_high_reg, key_low_reg};

    // pipeline entry
    assign req.ready = en;
    assign pipe[0]   = '{valid: req.valid,
                         kind:  req.kind,
                         blk:   {req.data_high, req.data_low},
                         key:   (req.kind == KIND_DEC) ? key_final(key_full) : key_full};

    // round stages
    for (genvar j = 0; j < ROUNDS; j++)
    begin : g_round
        gift_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .rnd   (RND_W'(j)),
            .prev  (pipe[j]),
            .curr  (pipe[j+1])
        );
    end

    // result channel
    gift_skid u_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .last  (pipe[ROUNDS]),
        .en    (en),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
